FILE: sv/shfc_pkg.sv
// Package for the single/half float converter.
// Status codes, direction codes and format constants; no dependencies.
package shfc_pkg;
	localparam int unsigned PipeDepth = 3;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_INF   = 2'd1,
		ST_NAN   = 2'd2,
		ST_CLAMP = 2'd3
	} status_t;

	localparam logic KIND_S2H = 1'b0;
	localparam logic KIND_H2S = 1'b1;

	localparam logic [15:0] HALF_MAX_POS = 16'h7BFF;
	localparam logic [15:0] HALF_MAX_NEG = 16'hFBFF;
	localparam logic [30:0] SINGLE_65504 = 31'h477FE000;
	localparam logic [7:0]  REBIAS       = 8'd112;

	typedef struct packed {
		logic       kind;
		logic       sgn;
		logic [7:0] ex;
		logic [22:0] man;
		logic [3:0] lz;
	} dec_t;
endpackage

FILE: sv/shfc_lzc10.sv
// Leading zero count of a 10-bit half mantissa.
// Uses nothing outside this file.
module shfc_lzc10 (
	input  logic [9:0] man,
	output logic [3:0] lz
);
	always_comb begin
		lz = 4'd10;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) lz = 4'(9 - i);
		end
	end
endmodule

FILE: sv/single_half_float_converter_core.sv
// Top level of the single/half float converter.
// Depends on shfc_pkg and shfc_lzc10.
//
// Input channel: valid, ready, kind, operand_bits. kind 0 converts a single
// to a half (result in bits 15..0), kind 1 converts the half in bits 15..0
// to a single. Output channel: out_valid, out_ready, result_bits, status,
// exact_ok. One result per request.
// Three pipeline stages: s1 registers the request, s2 splits the fields,
// counts leading zeros of half subnormals and checks range, s3 assembles
// and holds the result.
// One request is accepted per cycle while the receiver does not stall the output.
// The pipeline advances when the last stage is empty or being taken, so a
// stall by the receiver holds every stage and nothing is lost or repeated.
// Reset clears all stage valid bits.
module single_half_float_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        kind,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_bits,
	output logic [1:0]  status,
	output logic        exact_ok
);
	logic v_s1, v_s2, v_s3, adv;
	logic [31:0] op_s1;
	logic kind_s1;
	shfc_pkg::dec_t d_s2;
	logic big_s2;
	logic [3:0] lz;
	logic [31:0] res_nxt;
	shfc_pkg::status_t st_nxt;
	logic [31:0] res_s3;
	shfc_pkg::status_t st_s3;

	assign adv = !v_s3 || out_ready;
	assign ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= operand_bits;
			kind_s1 <= kind;
		end
	end

	shfc_lzc10 u_lzc (.man(op_s1[9:0]), .lz(lz));

	// stage 2: decode
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2.kind <= kind_s1;
			d_s2.lz <= lz;
			if (kind_s1 == shfc_pkg::KIND_S2H) begin
				d_s2.sgn <= op_s1[31];
				d_s2.ex <= op_s1[30:23];
				d_s2.man <= op_s1[22:0];
				big_s2 <= op_s1[30:0] > shfc_pkg::SINGLE_65504;
			end else begin
				d_s2.sgn <= op_s1[15];
				d_s2.ex <= {3'd0, op_s1[14:10]};
				d_s2.man <= {13'd0, op_s1[9:0]};
				big_s2 <= 1'b0;
			end
		end
	end

	// stage 3: assemble
	always_comb begin
		st_nxt = shfc_pkg::ST_NONE;
		if (d_s2.kind == shfc_pkg::KIND_S2H) begin
			if (d_s2.ex == 8'd0) begin
				res_nxt = {16'd0, d_s2.sgn, 15'd0};
			end else if (d_s2.ex == 8'hFF && d_s2.man == 23'd0) begin
				res_nxt = {16'd0,
					d_s2.sgn ? shfc_pkg::HALF_MAX_NEG : shfc_pkg::HALF_MAX_POS};
				st_nxt = shfc_pkg::ST_INF;
			end else if (d_s2.ex == 8'hFF) begin
				res_nxt = 32'd0;
				st_nxt = shfc_pkg::ST_NAN;
			end else if (big_s2) begin
				res_nxt = {16'd0,
					d_s2.sgn ? shfc_pkg::HALF_MAX_NEG : shfc_pkg::HALF_MAX_POS};
				st_nxt = shfc_pkg::ST_CLAMP;
			end else if (d_s2.ex <= shfc_pkg::REBIAS) begin
				res_nxt = {16'd0, d_s2.sgn, 15'd0};
			end else begin
				res_nxt = {16'd0, d_s2.sgn, 5'(d_s2.ex - shfc_pkg::REBIAS),
					d_s2.man[22:13]};
			end
		end else begin
			if (d_s2.ex == 8'h1F && d_s2.man[9:0] == 10'd0) begin
				res_nxt = {d_s2.sgn, shfc_pkg::SINGLE_65504};
				st_nxt = shfc_pkg::ST_INF;
			end else if (d_s2.ex == 8'h1F) begin
				res_nxt = 32'd0;
				st_nxt = shfc_pkg::ST_NAN;
			end else if (d_s2.ex == 8'd0 && d_s2.man[9:0] == 10'd0) begin
				res_nxt = {d_s2.sgn, 31'd0};
			end else if (d_s2.ex == 8'd0) begin
				res_nxt = {d_s2.sgn, 8'(8'd112 - {4'd0, d_s2.lz}),
					{(d_s2.man[9:0] << (d_s2.lz + 4'd1)), 13'd0}};
			end else begin
				res_nxt = {d_s2.sgn, d_s2.ex + shfc_pkg::REBIAS,
					d_s2.man[9:0], 13'd0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res_nxt;
			st_s3 <= st_nxt;
		end
	end

	assign out_valid = v_s3;
	assign result_bits = res_s3;
	assign status = st_s3;
	assign exact_ok = (st_s3 == shfc_pkg::ST_NONE);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bits))
		else $error("result changed under stall");
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> exact_ok == (status == shfc_pkg::ST_NONE))
		else $error("exact_ok disagrees with status");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> ready)
		else $error("empty output blocks input");
endmodule
